### src/znss_pkg.sv
// Package with constants, types and helpers of the subsequence search block
package znss_pkg;

  localparam int unsigned MAX_QUERY   = 1024;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned ADDR_W      = $clog2(MAX_QUERY);
  localparam int unsigned LEN_W       = ADDR_W + 1;
  localparam int unsigned SUM_W       = SAMPLE_BITS + ADDR_W + 1;
  localparam int unsigned SSQ_W       = 2 * SAMPLE_BITS + ADDR_W;
  localparam int unsigned NQ_W        = LEN_W + SSQ_W;
  localparam int unsigned S2_W        = 2 * SUM_W;
  localparam int unsigned NUM_W       = LEN_W + 1 + SAMPLE_BITS;
  localparam int unsigned FRAC_SH     = 18;
  localparam int unsigned D_W         = NUM_W - 1 + FRAC_SH + 1;
  localparam int unsigned QUO_W       = 16;
  localparam int unsigned ZW          = 16;
  localparam int unsigned RT_W        = 32;
  localparam int unsigned SQ_W        = 64;
  localparam int unsigned DIST_W      = 48;
  localparam int unsigned DROOT_W     = 24;
  localparam int unsigned LOC_W       = 32;
  localparam int unsigned CNT_W       = $clog2(QUO_W);

  localparam logic [LEN_W-1:0]   QLEN_RESET = LEN_W'(128);
  localparam logic [LEN_W-1:0]   QLEN_MIN   = LEN_W'(2);
  localparam logic [LEN_W-1:0]   QLEN_MAX   = LEN_W'(MAX_QUERY);
  localparam logic [DIST_W-1:0]  DIST_MAX   = '1;
  localparam logic [DROOT_W-1:0] DROOT_MAX  = '1;
  localparam logic [SQ_W-1:0]    SQ_BIT_TOP = SQ_W'(1) << (SQ_W - 2);
  localparam logic [QUO_W-1:0]   Z_MAG_NEG  = QUO_W'(1) << (ZW - 1);
  localparam logic [QUO_W-1:0]   Z_MAG_POS  = Z_MAG_NEG - QUO_W'(1);

  typedef enum logic [0:0] {
    REG_QUERY_LENGTH = 1'b0,
    REG_SKIP_MODE    = 1'b1
  } reg_idx_e;

  typedef enum logic [13:0] {
    S_IDLE  = 14'h0001,
    S_UPD   = 14'h0002,
    S_SETUP = 14'h0004,
    S_SQINI = 14'h0008,
    S_SQRT  = 14'h0010,
    S_LOOP  = 14'h0020,
    S_MUL   = 14'h0040,
    S_DLOAD = 14'h0080,
    S_DCHK  = 14'h0100,
    S_DIV   = 14'h0200,
    S_FIN   = 14'h0400,
    S_ACC   = 14'h0800,
    S_BSQRT = 14'h1000,
    S_OUT   = 14'h2000
  } state_e;

  // Clamp a written length into the legal range
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v < QLEN_MIN) r = QLEN_MIN;
    if (v > QLEN_MAX) r = QLEN_MAX;
    return r;
  endfunction

endpackage

### src/znss_ram.sv
// Generic single write port, single read port RAM with registered read
module znss_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Registered read; a read of the address being written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/znorm_euclidean_subsequence_search_top.sv
// Top level of the z-normalised Euclidean subsequence search.
// Query word: stored on arrival; the last query word also normalises the stored query.
// Data word: updates the window; a scored window then walks its elements (up to n,
// early abandon), each through the serial divider, and a square root when the best improves.
// Reset is asynchronous, active low; stores need no clearing pass, they are read only
// after being written.
module znorm_euclidean_subsequence_search_top
  import znss_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [LOC_W-1:0]              best_location_o,
  output logic [DIST_W-1:0]             best_sq_distance_o,
  output logic [DROOT_W-1:0]            best_distance_o,
  output logic                          improved_o,
  output logic                          found_o,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_index_i,
  input  logic [LEN_W-1:0]              cfg_wdata_i
);

  state_e state_q, state_d;

  // Architectural state
  logic [LEN_W-1:0]        qlen_q, qlen_d;
  logic                    skip_q, skip_d;
  logic [LEN_W-1:0]        qcount_q, qcount_d;
  logic signed [SUM_W-1:0] qsum_q, qsum_d, wsum_q, wsum_d;
  logic [SSQ_W-1:0]        qssq_q, qssq_d, wssq_q, wssq_d;
  logic [LOC_W-1:0]        dcount_q, dcount_d, dquo_q, dquo_d;
  logic [LEN_W-1:0]        drem_q, drem_d;
  logic [DIST_W-1:0]       best_q, best_d;
  logic [LOC_W-1:0]        bstart_q, bstart_d;
  logic [DROOT_W-1:0]      bdist_q, bdist_d;
  logic [ADDR_W-1:0]       ring_pos_q, ring_pos_d;
  logic                    full_q, full_d, found_q, found_d, improved_q, improved_d;
  logic                    mode_query_q, mode_query_d;
  logic                    out_valid_q, out_valid_d;

  // Datapath registers
  logic signed [SAMPLE_BITS-1:0] x_q, x_d;
  logic [NQ_W-1:0]   nq_q, nq_d;
  logic [S2_W-1:0]   s2_q, s2_d;
  logic              zero_q, zero_d;
  logic [SQ_W-1:0]   sqv_q, sqv_d, sqres_q, sqres_d, sqbit_q, sqbit_d;
  logic [RT_W-1:0]   r_q, r_d;
  logic [LEN_W-1:0]  k_q, k_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [DIST_W-1:0] acc_q, acc_d;
  logic signed [NUM_W-1:0] num_q, num_d;
  logic [ZW-1:0]     zq_q, zq_d;
  logic              neg_q, neg_d, ovf_q, ovf_d;
  logic [D_W-1:0]    dv_q, dv_d;
  logic [RT_W-1:0]   rem_q, rem_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RT_W-1:0]   sq_q, sq_d;
  logic [LOC_W-1:0]   o_loc_q, o_loc_d;
  logic [DIST_W-1:0]  o_sq_q, o_sq_d;
  logic [DROOT_W-1:0] o_dist_q, o_dist_d;
  logic               o_imp_q, o_imp_d, o_found_q, o_found_d;

  // Memory ports
  logic                   qram_we, ring_we;
  logic [ADDR_W-1:0]      qram_waddr, ring_raddr;
  logic [SAMPLE_BITS-1:0] qram_wdata, qram_rdata, ring_rdata;

  // Combinational helpers
  logic signed [2*SAMPLE_BITS-1:0] xin_sq, xq_sq, old_sq;
  logic signed [SAMPLE_BITS-1:0]   old_s, q_rd_s, x_sel;
  logic              q_restart, pos_wrap, score, loop_done, last_elem;
  logic [LEN_W-1:0]  q_idx, q_idx_nx, pos_nx, idx_nx;
  logic signed [SUM_W-1:0] sel_sum, wsum_up;
  logic [SSQ_W-1:0]  sel_ssq, wssq_up;
  logic [SUM_W-1:0]  sabs;
  logic [S2_W-1:0]   spread;
  logic [SQ_W-1:0]   sq_t, sqres_nx;
  logic              sq_ge;
  logic signed [NUM_W-1:0] prod;
  logic [NUM_W-1:0]  mag;
  logic [RT_W:0]     rem_sh;
  logic              div_ge;
  logic [QUO_W-1:0]  dlo;
  logic [ZW-1:0]     z_val;
  logic signed [ZW:0]      dz;
  logic signed [2*ZW+1:0]  dz_sq;
  logic [DIST_W:0]   acc_sum;
  logic [LOC_W-1:0]  bstart_nx;

  znss_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_QUERY)) u_query_ram (
    .clk_i   (clk_i),
    .we_i    (qram_we),
    .waddr_i (qram_waddr),
    .wdata_i (qram_wdata),
    .raddr_i (k_q[ADDR_W-1:0]),
    .rdata_o (qram_rdata)
  );

  znss_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_QUERY)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_pos_q),
    .wdata_i (x_q),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  // Query load arithmetic
  assign xin_sq    = sample_i * sample_i;
  assign q_restart = qcount_q >= qlen_q;
  assign q_idx     = q_restart ? '0 : qcount_q;
  assign q_idx_nx  = q_idx + LEN_W'(1);

  // Ring update arithmetic
  assign old_s   = $signed(ring_rdata);
  assign old_sq  = old_s * old_s;
  assign xq_sq   = x_q * x_q;
  assign wsum_up = (full_q ? wsum_q - SUM_W'(old_s) : wsum_q) + SUM_W'(x_q);
  assign wssq_up = (full_q ? wssq_q - SSQ_W'($unsigned(old_sq)) : wssq_q)
                   + SSQ_W'($unsigned(xq_sq));
  assign pos_nx   = LEN_W'(ring_pos_q) + LEN_W'(1);
  assign pos_wrap = pos_nx >= qlen_q;
  assign score    = (full_q || pos_wrap) && (qcount_q == qlen_q)
                    && (!skip_q || pos_wrap);
  assign ring_raddr = (state_q == S_LOOP) ? idx_q : ring_pos_q;

  // Spread of the selected sample set
  assign sel_sum = mode_query_q ? qsum_q : wsum_q;
  assign sel_ssq = mode_query_q ? qssq_q : wssq_q;
  assign sabs    = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
  assign spread  = S2_W'(nq_q) - s2_q;

  // One step of the bitwise square root
  assign sq_t     = sqres_q + sqbit_q;
  assign sq_ge    = sqv_q >= sq_t;
  assign sqres_nx = sq_ge ? (sqres_q >> 1) + sqbit_q : sqres_q >> 1;

  // Numerator n*x - S and its magnitude
  assign q_rd_s = $signed(qram_rdata);
  assign x_sel  = mode_query_q ? q_rd_s : old_s;
  assign prod   = $signed({1'b0, qlen_q}) * x_sel;
  assign mag    = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);

  // One quotient bit per cycle
  assign dlo    = dv_q[QUO_W-1:0];
  assign rem_sh = {rem_q, dlo[~cnt_q]};
  assign div_ge = rem_sh >= {1'b0, r_q};

  // Saturate and sign the rounded quotient
  always_comb begin
    z_val = '0;
    if (!zero_q) begin
      if (neg_q) begin
        z_val = (ovf_q || quo_q > Z_MAG_NEG) ? Z_MAG_NEG : QUO_W'(-quo_q);
      end else begin
        z_val = (ovf_q || quo_q > Z_MAG_POS) ? Z_MAG_POS : quo_q;
      end
    end
  end

  assign dz      = $signed({z_val[ZW-1], z_val}) - $signed({zq_q[ZW-1], zq_q});
  assign dz_sq   = dz * dz;
  assign acc_sum = {1'b0, acc_q} + (DIST_W+1)'(sq_q);
  assign idx_nx  = LEN_W'(idx_q) + LEN_W'(1);
  assign loop_done = (k_q == qlen_q) || (!mode_query_q && acc_q >= best_q);
  assign last_elem = sqbit_q[0];
  assign bstart_nx = skip_q ? dquo_q : dcount_q - LOC_W'(qlen_q) + LOC_W'(1);

  // Next-state logic
  always_comb begin
    state_d = state_q;
    qlen_d = qlen_q; skip_d = skip_q; qcount_d = qcount_q;
    qsum_d = qsum_q; qssq_d = qssq_q; wsum_d = wsum_q; wssq_d = wssq_q;
    dcount_d = dcount_q; dquo_d = dquo_q; drem_d = drem_q;
    best_d = best_q; bstart_d = bstart_q; bdist_d = bdist_q;
    ring_pos_d = ring_pos_q; full_d = full_q; found_d = found_q;
    improved_d = improved_q; mode_query_d = mode_query_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    x_d = x_q; nq_d = nq_q; s2_d = s2_q; zero_d = zero_q;
    sqv_d = sqv_q; sqres_d = sqres_q; sqbit_d = sqbit_q; r_d = r_q;
    k_d = k_q; idx_d = idx_q; acc_d = acc_q; num_d = num_q; zq_d = zq_q;
    neg_d = neg_q; ovf_d = ovf_q; dv_d = dv_q; rem_d = rem_q; quo_d = quo_q;
    cnt_d = cnt_q; sq_d = sq_q;
    o_loc_d = o_loc_q; o_sq_d = o_sq_q; o_dist_d = o_dist_q;
    o_imp_d = o_imp_q; o_found_d = o_found_q;
    qram_we = 1'b0; qram_waddr = q_idx[ADDR_W-1:0]; qram_wdata = sample_i;
    ring_we = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!func_i) begin
            // Store the query word and clear the search
            qram_we  = 1'b1;
            qsum_d   = (q_restart ? '0 : qsum_q) + SUM_W'(sample_i);
            qssq_d   = (q_restart ? '0 : qssq_q) + SSQ_W'($unsigned(xin_sq));
            qcount_d = q_idx_nx;
            wsum_d = '0; wssq_d = '0; dcount_d = '0; dquo_d = '0; drem_d = '0;
            best_d = DIST_MAX; bstart_d = '0; bdist_d = DROOT_MAX;
            ring_pos_d = '0; full_d = 1'b0; found_d = 1'b0;
            if (q_idx_nx == qlen_q) begin
              mode_query_d = 1'b1;
              state_d      = S_SETUP;
            end
          end else begin
            x_d     = sample_i;
            state_d = S_UPD;
          end
        end
      end
      S_UPD: begin
        // Drop the oldest word, add the new one, advance the ring
        ring_we    = 1'b1;
        wsum_d     = wsum_up;
        wssq_d     = wssq_up;
        ring_pos_d = pos_wrap ? '0 : pos_nx[ADDR_W-1:0];
        full_d     = full_q | pos_wrap;
        improved_d = 1'b0;
        dcount_d   = dcount_q + LOC_W'(1);
        if (dcount_q == '1) begin
          dquo_d = '0;
          drem_d = '0;
        end else if (drem_q + LEN_W'(1) == qlen_q) begin
          dquo_d = dquo_q + LOC_W'(1);
          drem_d = '0;
        end else begin
          drem_d = drem_q + LEN_W'(1);
        end
        mode_query_d = 1'b0;
        state_d      = score ? S_SETUP : S_OUT;
      end
      S_SETUP: begin
        nq_d    = NQ_W'(qlen_q) * NQ_W'(sel_ssq);
        s2_d    = S2_W'(sabs) * S2_W'(sabs);
        state_d = S_SQINI;
      end
      S_SQINI: begin
        zero_d  = S2_W'(nq_q) <= s2_q;
        sqv_d   = SQ_W'({spread, 12'b0});
        sqres_d = '0;
        sqbit_d = SQ_BIT_TOP;
        state_d = S_SQRT;
      end
      S_SQRT, S_BSQRT: begin
        if (sq_ge) sqv_d = sqv_q - sq_t;
        sqres_d = sqres_nx;
        sqbit_d = sqbit_q >> 2;
        if (last_elem) begin
          if (state_q == S_SQRT) begin
            r_d     = sqres_nx[RT_W-1:0];
            k_d     = '0;
            idx_d   = ring_pos_q;
            acc_d   = '0;
            state_d = S_LOOP;
          end else begin
            bdist_d = sqres_nx[DROOT_W-1:0];
            state_d = S_OUT;
          end
        end
      end
      S_LOOP: begin
        if (loop_done) begin
          if (mode_query_q) begin
            state_d = S_IDLE;
          end else begin
            found_d = 1'b1;
            if (acc_q < best_q) begin
              best_d     = acc_q;
              bstart_d   = bstart_nx;
              improved_d = 1'b1;
              sqv_d      = SQ_W'(acc_q);
              sqres_d    = '0;
              sqbit_d    = SQ_BIT_TOP;
              state_d    = S_BSQRT;
            end else begin
              state_d = S_OUT;
            end
          end
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        num_d   = NUM_W'(prod) - NUM_W'(sel_sum);
        zq_d    = qram_rdata;
        state_d = S_DLOAD;
      end
      S_DLOAD: begin
        neg_d   = num_q[NUM_W-1];
        dv_d    = D_W'({mag[NUM_W-2:0], FRAC_SH'(0)}) + D_W'(r_q >> 1);
        state_d = S_DCHK;
      end
      S_DCHK: begin
        ovf_d   = RT_W'(dv_q[D_W-1:QUO_W]) >= r_q;
        rem_d   = RT_W'(dv_q[D_W-1:QUO_W]);
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = div_ge ? RT_W'(rem_sh - {1'b0, r_q}) : rem_sh[RT_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], div_ge};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == '1) state_d = S_FIN;
      end
      S_FIN: begin
        if (mode_query_q) begin
          // Replace the stored query word by its z value
          qram_we    = 1'b1;
          qram_waddr = k_q[ADDR_W-1:0];
          qram_wdata = z_val;
        end else begin
          sq_d = dz_sq[RT_W-1:0];
        end
        state_d = S_ACC;
      end
      S_ACC: begin
        if (!mode_query_q) acc_d = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];
        k_d     = k_q + LEN_W'(1);
        idx_d   = (idx_nx == qlen_q) ? '0 : idx_nx[ADDR_W-1:0];
        state_d = S_LOOP;
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_loc_d   = bstart_q;
          o_sq_d    = best_q;
          o_dist_d  = bdist_q;
          o_imp_d   = improved_q;
          o_found_d = found_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Register writes must arrive only while idle; the block itself does not enforce it
    if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_QUERY_LENGTH: begin
          qlen_d = sat_len(cfg_wdata_i);
          qcount_d = '0; qsum_d = '0; qssq_d = '0;
          wsum_d = '0; wssq_d = '0; dcount_d = '0; dquo_d = '0; drem_d = '0;
          best_d = DIST_MAX; bstart_d = '0; bdist_d = DROOT_MAX;
          ring_pos_d = '0; full_d = 1'b0; found_d = 1'b0;
        end
        REG_SKIP_MODE: skip_d = cfg_wdata_i[0];
      endcase
    end
  end

  // Control and search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      qlen_q <= QLEN_RESET; skip_q <= 1'b0; qcount_q <= '0;
      qsum_q <= '0; qssq_q <= '0; wsum_q <= '0; wssq_q <= '0;
      dcount_q <= '0; dquo_q <= '0; drem_q <= '0;
      best_q <= DIST_MAX; bstart_q <= '0; bdist_q <= DROOT_MAX;
      ring_pos_q <= '0; full_q <= 1'b0; found_q <= 1'b0; improved_q <= 1'b0;
      mode_query_q <= 1'b0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      qlen_q <= qlen_d; skip_q <= skip_d; qcount_q <= qcount_d;
      qsum_q <= qsum_d; qssq_q <= qssq_d; wsum_q <= wsum_d; wssq_q <= wssq_d;
      dcount_q <= dcount_d; dquo_q <= dquo_d; drem_q <= drem_d;
      best_q <= best_d; bstart_q <= bstart_d; bdist_q <= bdist_d;
      ring_pos_q <= ring_pos_d; full_q <= full_d; found_q <= found_d;
      improved_q <= improved_d; mode_query_q <= mode_query_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and output words
  always_ff @(posedge clk_i) begin
    x_q <= x_d; nq_q <= nq_d; s2_q <= s2_d; zero_q <= zero_d;
    sqv_q <= sqv_d; sqres_q <= sqres_d; sqbit_q <= sqbit_d; r_q <= r_d;
    k_q <= k_d; idx_q <= idx_d; acc_q <= acc_d; num_q <= num_d; zq_q <= zq_d;
    neg_q <= neg_d; ovf_q <= ovf_d; dv_q <= dv_d; rem_q <= rem_d;
    quo_q <= quo_d; cnt_q <= cnt_d; sq_q <= sq_d;
    o_loc_q <= o_loc_d; o_sq_q <= o_sq_d; o_dist_q <= o_dist_d;
    o_imp_q <= o_imp_d; o_found_q <= o_found_d;
  end

  assign in_ready_o         = (state_q == S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign best_location_o    = o_loc_q;
  assign best_sq_distance_o = o_sq_q;
  assign best_distance_o    = o_dist_q;
  assign improved_o         = o_imp_q;
  assign found_o            = o_found_q;

  // Ring position stays inside the window
  a_ring_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(ring_pos_q) < qlen_q) else $error("ring position beyond window");

  // Query fill never passes the length
  a_qcount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcount_q <= qlen_q) else $error("query count beyond length");

  // Element walk runs only on a complete query
  a_loop_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOP |-> qcount_q == qlen_q) else $error("walk on incomplete query");

  // An improvement implies a scored window
  a_improved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && improved_o |-> found_o) else $error("improved without found");

  // Window-count remainder stays below the length
  a_drem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drem_q < qlen_q) else $error("window remainder out of range");

endmodule
